// ----- rtl/tss_pkg.sv -----
// ----------------------------------------------------------------------------
// tss_pkg: thumbwheel scan start/stop shared types
// Transaction payloads, switch control groups and scan constants.
// ----------------------------------------------------------------------------
package tss_pkg;

  typedef struct packed {
    logic [15:0] elapsed_ticks;
    logic [7:0]  column_sense;
    logic        start_level;
    logic        stop_level;
  } in_t;

  typedef struct packed {
    logic [7:0]  drive_a;
    logic [7:0]  drive_b;
    logic [17:0] speed_value;
    logic [17:0] reverse_count;
    logic [17:0] forward_count;
    logic [20:0] cycle_total;
    logic        values_ready;
    logic        running;
    logic        halted;
  } out_t;

  typedef struct packed {
    logic        en;
    logic [15:0] elapsed;
    logic        start_level;
    logic        stop_level;
    logic        speed_nz;
  } sw_req_t;

  typedef struct packed {
    logic running;
    logic halted;
  } sw_flags_t;

  localparam logic [1:0]  CFG_SCAN_PERIOD     = 2'd0;
  localparam logic [1:0]  CFG_SWITCH_DEBOUNCE = 2'd1;

  localparam logic [15:0] SCAN_PERIOD_RST     = 16'd10;
  localparam logic [15:0] SWITCH_DEBOUNCE_RST = 16'd50;

  localparam logic [3:0]  BANK_A_COLS = 4'd8;
  localparam logic [1:0]  BANK_B_COLS = 2'd3;
  localparam int          NUM_COLS    = 11;

  localparam logic [3:0]  COL_TOP     = 4'd10;
  localparam logic [3:0]  COL_SPLIT   = 4'd5;
  localparam logic [3:0]  COL_LOW_TOP = 4'd4;
  localparam logic [3:0]  COL_BOTTOM  = 4'd0;

endpackage

// ----- rtl/tss_digit_acc.sv -----
// ----------------------------------------------------------------------------
// tss_digit_acc: decimal digit accumulator
// Takes one digit nibble per cycle while en_i is high, most significant first: acc = acc*10 + d.
// ----------------------------------------------------------------------------
module tss_digit_acc (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic        clr_i,
  input  logic [3:0]  nibble_i,
  output logic [20:0] sum_o
);

  logic [20:0] acc_q;
  logic [20:0] base;

  assign base  = clr_i ? 21'd0 : acc_q;
  assign sum_o = (base << 3) + (base << 1) + {17'd0, nibble_i};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q <= sum_o;
    end
  end

endmodule

// ----- rtl/tss_switch.sv -----
// ----------------------------------------------------------------------------
// tss_switch: start/stop debounce
// Accumulates press time per transaction and toggles run and halt flags.
// ----------------------------------------------------------------------------
module tss_switch (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tss_pkg::sw_req_t   req_i,
  input  logic [15:0]        debounce_i,
  output tss_pkg::sw_flags_t flags_o
);

  logic [16:0] start_q, start_d;
  logic [16:0] stop_q, stop_d;
  logic        run_q, run_d;
  logic        halt_q, halt_d;

  always_comb begin
    start_d = start_q;
    stop_d  = stop_q;
    run_d   = run_q;
    halt_d  = halt_q;
    if (req_i.en) begin
      if (halt_d) begin
        if (!req_i.start_level && req_i.speed_nz) begin
          if (!run_d) begin
            start_d = start_d + {1'b0, req_i.elapsed};
            if (start_d >= {1'b0, debounce_i}) begin
              run_d   = 1'b1;
              halt_d  = 1'b0;
              start_d = 17'd0;
            end
          end
        end else begin
          start_d = 17'd0;
        end
      end
      if (run_d) begin
        if (!req_i.stop_level) begin
          if (!halt_d) begin
            stop_d = stop_d + {1'b0, req_i.elapsed};
            if (stop_d >= {1'b0, debounce_i}) begin
              halt_d = 1'b1;
              run_d  = 1'b0;
              stop_d = 17'd0;
            end
          end
        end else begin
          stop_d = 17'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 17'd0;
      stop_q  <= 17'd0;
      run_q   <= 1'b0;
      halt_q  <= 1'b1;
    end else begin
      start_q <= start_d;
      stop_q  <= stop_d;
      run_q   <= run_d;
      halt_q  <= halt_d;
    end
  end

  assign flags_o.running = run_q;
  assign flags_o.halted  = halt_q;

endmodule

// ----- rtl/thumbwheel_scan_start_stop_core.sv -----
// ----------------------------------------------------------------------------
// thumbwheel_scan_start_stop_core: thumbwheel matrix scanner with start/stop
// Column scan, digit capture, digit-serial decimal conversion and debounce.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one transaction per timer tick (elapsed time, sense byte,
//                 start and stop pin levels). Exactly one out transaction
//                 follows each in transaction.
//   out channel : column drives, the four converted values and the flags.
//   cfg channel : index 0 scan_period, index 1 switch_debounce; always ready,
//                 write only while the block is idle.
//   Conversion  : on the tick that finishes a scan, the conversion walks the
//                 11 stored columns one digit per cycle through two shared
//                 multiply-by-ten accumulators.
//   Acceptance  : a new tick is taken only once the previous one is through;
//                 it is accepted while the previous result waits in the
//                 output register.
//   Reset       : drives all ones, values zero, halted set, running clear,
//                 registers back to 10 and 50. The digit store is not cleared.
//   Stall       : a held result blocks the next one; the core waits in its
//                 output step until out_ready_i is high.
// ----------------------------------------------------------------------------
module thumbwheel_scan_start_stop_core #(
  parameter int unsigned HOLD_PERIODS = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  tss_pkg::in_t     in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output tss_pkg::out_t    out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [15:0]      cfg_data_i
);

  localparam int HW = (HOLD_PERIODS > 1) ? $clog2(HOLD_PERIODS) : 1;
  localparam logic [HW-1:0] HOLD_LAST = HW'(HOLD_PERIODS - 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EVAL   = 3'd1;
  localparam logic [2:0] ST_CONV   = 3'd2;
  localparam logic [2:0] ST_SWITCH = 3'd3;
  localparam logic [2:0] ST_OUT    = 3'd4;

  logic [2:0]   state_q;
  tss_pkg::in_t item_q;
  logic [15:0]  scan_period_q;
  logic [15:0]  debounce_q;
  logic [16:0]  scan_timer_q;
  logic [HW-1:0] hold_q;
  logic [3:0]   bank_a_q;
  logic [1:0]   bank_b_q;
  logic [7:0]   digit_q [tss_pkg::NUM_COLS];
  logic [7:0]   drive_a_q;
  logic [7:0]   drive_b_q;
  logic [17:0]  speed_q;
  logic [17:0]  reverse_q;
  logic [17:0]  forward_q;
  logic [20:0]  cycle_q;
  logic         ready_q;
  logic [3:0]   col_q;
  logic         out_valid_q;
  tss_pkg::out_t out_q;

  tss_pkg::sw_req_t   sw_req;
  tss_pkg::sw_flags_t sw_flags;

  logic [16:0]  scan_sum;
  logic         scan_fire;
  logic         in_bank_a;
  logic         in_bank_b;
  logic         hold_end;
  logic         do_store;
  logic         out_free;

  logic [7:0]   conv_byte;
  logic         conv_en;
  logic         acc_clr;
  logic [3:0]   lo_nib;
  logic [20:0]  lo_sum;
  logic [20:0]  hi_sum;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  assign scan_sum  = scan_timer_q + {1'b0, item_q.elapsed_ticks};
  assign scan_fire = sw_flags.halted && (scan_sum >= {1'b0, scan_period_q});
  assign in_bank_a = (bank_a_q < tss_pkg::BANK_A_COLS);
  assign in_bank_b = !in_bank_a && (bank_b_q < tss_pkg::BANK_B_COLS);
  assign hold_end  = (hold_q == HOLD_LAST);
  assign do_store  = (state_q == ST_EVAL) && scan_fire && (in_bank_a || in_bank_b) && hold_end;

  assign conv_byte = digit_q[tss_pkg::NUM_COLS-1];
  assign conv_en   = (state_q == ST_CONV);
  assign acc_clr   = (col_q == tss_pkg::COL_TOP) || (col_q == tss_pkg::COL_LOW_TOP);
  assign lo_nib    = (col_q == tss_pkg::COL_TOP) ? 4'd0 : conv_byte[3:0];

  tss_digit_acc u_acc_lo (
    .clk_i    (clk_i),
    .en_i     (conv_en),
    .clr_i    (acc_clr),
    .nibble_i (lo_nib),
    .sum_o    (lo_sum)
  );

  tss_digit_acc u_acc_hi (
    .clk_i    (clk_i),
    .en_i     (conv_en),
    .clr_i    (acc_clr),
    .nibble_i (conv_byte[7:4]),
    .sum_o    (hi_sum)
  );

  assign sw_req.en          = (state_q == ST_SWITCH);
  assign sw_req.elapsed     = item_q.elapsed_ticks;
  assign sw_req.start_level = item_q.start_level;
  assign sw_req.stop_level  = item_q.stop_level;
  assign sw_req.speed_nz    = (speed_q != 18'd0);

  tss_switch u_switch (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (sw_req),
    .debounce_i (debounce_q),
    .flags_o    (sw_flags)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      scan_period_q <= tss_pkg::SCAN_PERIOD_RST;
      debounce_q    <= tss_pkg::SWITCH_DEBOUNCE_RST;
      scan_timer_q  <= 17'd0;
      hold_q        <= '0;
      bank_a_q      <= 4'd0;
      bank_b_q      <= 2'd0;
      drive_a_q     <= 8'hff;
      drive_b_q     <= 8'hff;
      speed_q       <= 18'd0;
      reverse_q     <= 18'd0;
      forward_q     <= 18'd0;
      cycle_q       <= 21'd0;
      ready_q       <= 1'b0;
      col_q         <= 4'd0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          tss_pkg::CFG_SCAN_PERIOD:     scan_period_q <= cfg_data_i;
          tss_pkg::CFG_SWITCH_DEBOUNCE: debounce_q    <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          state_q <= (scan_fire && !in_bank_a && !in_bank_b) ? ST_CONV : ST_SWITCH;
          if (sw_flags.halted) begin
            scan_timer_q <= scan_fire ? 17'd0 : scan_sum;
          end
          if (scan_fire) begin
            if (in_bank_a || in_bank_b) begin
              hold_q <= hold_end ? '0 : hold_q + HW'(1);
            end
            if (in_bank_a) begin
              drive_a_q <= ~(8'd1 << bank_a_q[2:0]);
              drive_b_q <= 8'hff;
              if (hold_end) begin
                bank_a_q <= bank_a_q + 4'd1;
              end
            end else if (in_bank_b) begin
              drive_b_q <= ~(8'd1 << bank_b_q);
              drive_a_q <= 8'hff;
              if (hold_end) begin
                bank_b_q <= bank_b_q + 2'd1;
              end
            end else begin
              bank_a_q <= 4'd0;
              bank_b_q <= 2'd0;
              col_q    <= tss_pkg::COL_TOP;
            end
          end
        end
        ST_CONV: begin
          if (col_q == tss_pkg::COL_SPLIT) begin
            forward_q <= lo_sum[17:0];
            cycle_q   <= hi_sum;
          end
          if (col_q == tss_pkg::COL_BOTTOM) begin
            speed_q   <= lo_sum[17:0];
            reverse_q <= hi_sum[17:0];
            ready_q   <= 1'b1;
            state_q   <= ST_SWITCH;
          end else begin
            col_q <= col_q - 4'd1;
          end
        end
        ST_SWITCH: begin
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
    if (do_store) begin
      for (int i = 0; i < tss_pkg::NUM_COLS - 1; i++) begin
        digit_q[i] <= digit_q[i+1];
      end
      digit_q[tss_pkg::NUM_COLS-1] <= ~item_q.column_sense;
    end else if (conv_en) begin
      for (int i = 1; i < tss_pkg::NUM_COLS; i++) begin
        digit_q[i] <= digit_q[i-1];
      end
    end
    if (state_q == ST_OUT && out_free) begin
      out_q.drive_a       <= drive_a_q;
      out_q.drive_b       <= drive_b_q;
      out_q.speed_value   <= speed_q;
      out_q.reverse_count <= reverse_q;
      out_q.forward_count <= forward_q;
      out_q.cycle_total   <= cycle_q;
      out_q.values_ready  <= ready_q;
      out_q.running       <= sw_flags.running;
      out_q.halted        <= sw_flags.halted;
    end
  end

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sw_flags.running != sw_flags.halted)
    else $error("running and halted flags not complementary");

  a_one_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({~drive_a_q, ~drive_b_q}) <= 1)
    else $error("more than one column driven low");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV) |-> (col_q <= tss_pkg::COL_TOP))
    else $error("conversion column out of range");

  a_out_from_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_OUT))
    else $error("result raised outside the output step");

endmodule
